// ----- rtl/head_length_tail_frame_receiver_top_macros.svh -----
// assertion macros used by the frame receiver core (hlt_rx_core)
`ifndef HEAD_LENGTH_TAIL_FRAME_RECEIVER_TOP_MACROS_SVH
`define HEAD_LENGTH_TAIL_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication, sampled on clk, off while in reset
`define HLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// ----- rtl/hlt_pkg.sv -----
// types and constants of the head/length/tail frame receiver
`default_nettype none
package hlt_pkg;

  localparam logic [7:0] FRAME_HEAD   = 8'h3C;
  localparam logic [7:0] FRAME_TAIL   = 8'h0D;
  localparam logic [7:0] MAX_DATA_LEN = 8'd64;

  localparam int OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_TAIL = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_HEAD = 3'd1,
    ERR_BAD_TYPE = 3'd2,
    ERR_TOO_LONG = 3'd3,
    ERR_BAD_TAIL = 3'd4,
    ERR_HELD     = 3'd5
  } err_t;

  typedef enum logic {
    CFG_TYPE_FLOOR   = 1'b0,
    CFG_TYPE_CEILING = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       kept;
    logic [6:0] position;
    logic [7:0] kept_byte;
    phase_t     phase;
    logic       frame_done;
    err_t       error_code;
    logic [6:0] frame_length;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/head_length_tail_frame_receiver_top.sv -----
// top level of the head/length/tail frame receiver
//
//   channel  | direction | tdata / data                       | tuser / extra
//   ---------+-----------+------------------------------------+----------------
//   in_      | slave     | rx_byte                            | cmd
//   out_     | master    | kept..frame_length (see port list) | tlast=frame_done
//   cfg_     | slave     | cfg_data (8 bit)                   | cfg_index
//
// one byte per cycle sustained while out_tready stays high: input register, then decode, then result register
// a result shows on the bus once it has moved from the input register into the result register
// rst_n is synchronous; it empties both registers and returns the receiver to idle
// a stall on out_tready holds the result register and, once the input register is
// also full, drops in_tready; no transfer is lost or repeated
`default_nettype none
module head_length_tail_frame_receiver_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // slave-side stream
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] rx_byte
  input  wire logic                       in_tuser,   // [0] cmd (1 = restart)
  // master-side stream
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [0] kept, [7:1] position, [15:8] kept_byte, [18:16] phase,
  // [21:19] error_code, [28:22] frame_length, [31:29] zero
  output logic [hlt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,  // frame_done
  // configuration writes
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [7:0]                 cfg_data
);
  import hlt_pkg::*;

  // input register
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;

  // type window registers
  logic [7:0] type_floor_r;
  logic [7:0] type_ceiling_r;

  logic space;
  logic advance;
  res_t res;

  // an item leaves the input register when the result register can take it
  assign advance   = s1_valid_r && space;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // configuration transfers, accepted on any cycle; meant for idle periods
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_floor_r   <= 8'd0;
      type_ceiling_r <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TYPE_FLOOR:   type_floor_r   <= cfg_data;
        CFG_TYPE_CEILING: type_ceiling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hlt_rx_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .cmd          (s1_cmd_r),
    .rx_byte      (s1_byte_r),
    .type_floor   (type_floor_r),
    .type_ceiling (type_ceiling_r),
    .res          (res)
  );

  hlt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/hlt_rx_core.sv -----
// frame tracking state and per-byte decode
`default_nettype none
`include "head_length_tail_frame_receiver_top_macros.svh"
module hlt_rx_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic          cmd,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [7:0]    type_floor,
  input  wire logic [7:0]    type_ceiling,
  output hlt_pkg::res_t      res
);
  import hlt_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] decl_len_r, decl_len_nxt;
  logic [7:0] data_cnt_r, data_cnt_nxt;
  logic [7:0] wr_off_r, wr_off_nxt;
  err_t       err;
  logic       done;
  logic       kept;

  always_comb begin
    phase_nxt    = phase_r;
    decl_len_nxt = decl_len_r;
    data_cnt_nxt = data_cnt_r;
    wr_off_nxt   = wr_off_r;
    err          = ERR_NONE;
    done         = 1'b0;
    kept         = 1'b0;
    if (cmd) begin
      phase_nxt    = PH_IDLE;
      decl_len_nxt = '0;
      data_cnt_nxt = '0;
      wr_off_nxt   = '0;
    end else if (phase_r == PH_DONE) begin
      err = ERR_HELD;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == FRAME_HEAD) phase_nxt = PH_HEAD;
          else err = ERR_NOT_HEAD;
        end
        PH_HEAD: begin
          if ((type_floor < rx_byte) && (rx_byte < type_ceiling)) phase_nxt = PH_TYPE;
          else err = ERR_BAD_TYPE;
        end
        PH_TYPE: begin
          if (rx_byte <= MAX_DATA_LEN) begin
            phase_nxt    = PH_DATA;
            decl_len_nxt = rx_byte;
          end else begin
            err = ERR_TOO_LONG;
          end
        end
        PH_DATA: begin
          // checksum byte is the one after the last data byte
          if (data_cnt_r < decl_len_r) data_cnt_nxt = data_cnt_r + 8'd1;
          else phase_nxt = PH_TAIL;
        end
        PH_TAIL: begin
          if (rx_byte == FRAME_TAIL) begin
            phase_nxt = PH_DONE;
            done      = 1'b1;
          end else begin
            err = ERR_BAD_TAIL;
          end
        end
        default: err = ERR_NOT_HEAD;
      endcase
      if (err == ERR_NONE) begin
        kept       = 1'b1;
        wr_off_nxt = wr_off_r + 8'd1;
      end else begin
        phase_nxt    = PH_IDLE;
        decl_len_nxt = '0;
        data_cnt_nxt = '0;
        wr_off_nxt   = '0;
      end
    end
  end

  always_comb begin
    res.kept         = kept;
    res.position     = kept ? wr_off_r[6:0] : 7'd0;
    res.kept_byte    = kept ? rx_byte : 8'd0;
    res.phase        = phase_nxt;
    res.frame_done   = done;
    res.error_code   = err;
    res.frame_length = decl_len_nxt[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      decl_len_r <= '0;
      data_cnt_r <= '0;
      wr_off_r   <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      decl_len_r <= decl_len_nxt;
      data_cnt_r <= data_cnt_nxt;
      wr_off_r   <= wr_off_nxt;
    end
  end

  // a held frame stays held until a restart
  `HLT_ASSERT_NEXT(a_held_stays, advance && !cmd && (phase_r == PH_DONE), phase_r == PH_DONE)
  // restart leaves the receiver idle with the offset cleared
  `HLT_ASSERT_NEXT(a_restart_idle, advance && cmd, (phase_r == PH_IDLE) && (wr_off_r == 8'd0))
  // each kept byte moves the write offset on by one
  `HLT_ASSERT_NEXT(a_offset_step, advance && kept, wr_off_r == $past(wr_off_r) + 8'd1)
  // the data counter never runs past the declared length
  `HLT_ASSERT_NOW(a_count_bound, 1'b1, data_cnt_r <= decl_len_r)

endmodule
`default_nettype wire

// ----- rtl/hlt_out_stage.sv -----
// result register in front of the master-side stream
`default_nettype none
module hlt_out_stage (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                load,
  input  wire hlt_pkg::res_t                       res,
  output logic                                     space,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [hlt_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                     out_tlast
);
  import hlt_pkg::*;

  logic valid_r;
  res_t res_r;

  assign space = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) res_r <= res;
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {3'b000, res_r.frame_length, res_r.error_code, res_r.phase,
                       res_r.kept_byte, res_r.position, res_r.kept};

endmodule
`default_nettype wire
